// ----- hdl/ahpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ahpc_pkg
// Shared types, codes and character classes for the authority host/port
// checker.
// ----------------------------------------------------------------------------
package ahpc_pkg;

   // field widths
   localparam int CH_W     = 8;
   localparam int COUNT_W  = 10;
   localparam int PORT_W   = 16;
   localparam int ACCUM_W  = 17;
   localparam int ERR_W    = 3;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   typedef logic [CH_W-1:0]    byte_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ACCUM_W-1:0] accum_type;
   typedef logic [ERR_W-1:0]   err_type;

   // verdict codes
   localparam err_type ERR_OK    = 3'd0;
   localparam err_type ERR_LONG  = 3'd1;
   localparam err_type ERR_FIRST = 3'd2;
   localparam err_type ERR_CHAR  = 3'd3;
   localparam err_type ERR_PAIR  = 3'd4;
   localparam err_type ERR_COLON = 3'd5;
   localparam err_type ERR_PORT  = 3'd6;
   localparam err_type ERR_LAST  = 3'd7;

   // register map
   localparam logic [CSR_AW-1:0] CSR_MAX_LENGTH_ADDR = 2'd0;
   localparam count_type MAX_LENGTH_RESET = 10'd255;

   // limits
   localparam count_type COUNT_MAX = 10'h3FF;
   localparam accum_type PORT_SAT  = 17'd65536;

   // characters
   localparam byte_type CH_DOT   = 8'h2E;
   localparam byte_type CH_DASH  = 8'h2D;
   localparam byte_type CH_COLON = 8'h3A;
   localparam byte_type CH_ZERO  = 8'h30;
   localparam byte_type CH_NINE  = 8'h39;
   localparam byte_type CH_LA    = 8'h61;
   localparam byte_type CH_LZ    = 8'h7A;
   localparam byte_type CH_UA    = 8'h41;
   localparam byte_type CH_UZ    = 8'h5A;

   function automatic logic is_digit(input byte_type c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alnum(input byte_type c);
      return is_digit(c) || ((c >= CH_LA) && (c <= CH_LZ)) ||
             ((c >= CH_UA) && (c <= CH_UZ));
   endfunction

   function automatic logic is_sep(input byte_type c);
      return (c == CH_DOT) || (c == CH_DASH) || (c == CH_COLON);
   endfunction

endpackage

// ----- hdl/ahpc_ifs.sv -----
// ----------------------------------------------------------------------------
// ahpc request and result channels
// Valid/ready channels carrying one authority byte and one verdict.
// ----------------------------------------------------------------------------
interface ahpc_req_if;
   import ahpc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  ch;
   logic             last;

   modport source (output valid, ch, last, input ready);
   modport sink   (input valid, ch, last, output ready);
endinterface

interface ahpc_rsp_if;
   import ahpc_pkg::*;

   logic                valid;
   logic                ready;
   logic                valid_res;
   logic [ERR_W-1:0]    error;
   logic                has_port;
   logic [PORT_W-1:0]   port;
   logic [COUNT_W-1:0]  auth_length;

   modport source (output valid, valid_res, error, has_port, port, auth_length,
                   input ready);
   modport sink   (input valid, valid_res, error, has_port, port, auth_length,
                   output ready);
endinterface

// ----- hdl/authority_host_port_check.sv -----
// ----------------------------------------------------------------------------
// authority_host_port_check
// Checks the host and optional port of a URL authority, one byte a cycle while not stalled.
// ----------------------------------------------------------------------------
// verdict path: a last byte is registered in the input stage, checked there
// and its verdict registered in the result stage, where it waits for ready
// throughput: one byte per cycle, set by the single per-byte check stage,
// except that a waiting verdict stalls a last byte and the bytes behind it
// reset: synchronous, clears the run state, both stages and max_length to 255
module authority_host_port_check (
   input  logic                         clock,
   input  logic                         reset,
   ahpc_req_if.sink                     req_bus,
   ahpc_rsp_if.source                   rsp_bus,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ahpc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ahpc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ahpc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import ahpc_pkg::*;

   // configuration
   count_type max_length_ff, max_length_in;

   // input stage
   logic     in_valid_ff, in_valid_in;
   byte_type in_ch_ff, in_ch_in;
   logic     in_last_ff, in_last_in;

   // run state
   count_type count_ff, count_in;
   byte_type  prev_ff, prev_in;
   logic      pmode_ff, pmode_in;
   accum_type accum_ff, accum_in;
   err_type   ferr_ff, ferr_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   logic              out_ok_ff, out_ok_in;
   err_type           out_err_ff, out_err_in;
   logic              out_hasp_ff, out_hasp_in;
   logic [PORT_W-1:0] out_port_ff, out_port_in;
   count_type         out_len_ff, out_len_in;

   // step signals
   logic      advance, step, first, sat, pair_bad, colon_new, digit_add;
   err_type   err_a, err_b, err_c, verdict;
   count_type count_next;
   logic      pmode_next;
   accum_type accum_next;
   logic [19:0] accum_x10;

   // apb port, always ready
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_MAX_LENGTH_ADDR) ?
                       {{(CSR_DW-COUNT_W){1'b0}}, max_length_ff} : '0;

   always_comb begin
      max_length_in = max_length_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_MAX_LENGTH_ADDR) begin
         max_length_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   // a byte in the input stage moves on unless it is a last byte blocked by a
   // verdict still waiting
   assign advance = !in_last_ff || !out_valid_ff || rsp_bus.ready;
   assign step    = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      in_last_in  = in_last_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_ch_in    = req_bus.ch;
         in_last_in  = req_bus.last;
      end
   end

   // per-byte checks, first error wins, except that a saturated count forces ERR_LONG
   assign first      = (count_ff == '0);
   assign sat        = (count_ff == COUNT_MAX);
   assign count_next = sat ? count_ff : count_ff + 1'b1;
   assign err_a      = sat ? ERR_LONG : ferr_ff;

   assign pair_bad = !first && is_sep(prev_ff) && is_sep(in_ch_ff) &&
                     !((prev_ff == in_ch_ff) &&
                       ((in_ch_ff == CH_DASH) || (in_ch_ff == CH_COLON)));

   always_comb begin
      err_b = err_a;
      if (err_a == ERR_OK && pair_bad) begin
         err_b = ERR_PAIR;
      end
      err_c = err_b;
      if (err_b == ERR_OK) begin
         if (first && !is_alnum(in_ch_ff)) begin
            err_c = ERR_FIRST;
         end else if (pmode_ff ? !is_digit(in_ch_ff)
                               : !(is_alnum(in_ch_ff) || is_sep(in_ch_ff))) begin
            err_c = ERR_CHAR;
         end else if (in_ch_ff == CH_COLON && !pmode_ff && in_last_ff) begin
            err_c = ERR_COLON;
         end
      end
   end

   // port separator and saturating port accumulator
   assign colon_new  = (in_ch_ff == CH_COLON) && !pmode_ff;
   assign pmode_next = pmode_ff || (colon_new && !in_last_ff);
   assign digit_add  = !colon_new && pmode_ff && is_digit(in_ch_ff);
   assign accum_x10  = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0} +
                       {12'd0, in_ch_ff - CH_ZERO};

   always_comb begin
      accum_next = accum_ff;
      if (digit_add) begin
         accum_next = (accum_x10 > {3'd0, PORT_SAT}) ? PORT_SAT
                                                     : accum_x10[ACCUM_W-1:0];
      end
   end

   // verdict on the last byte
   always_comb begin
      if (err_c == ERR_LONG || count_next > max_length_ff) begin
         verdict = ERR_LONG;
      end else if (err_c != ERR_OK) begin
         verdict = err_c;
      end else if (pmode_next && accum_next[ACCUM_W-1]) begin
         verdict = ERR_PORT;
      end else if (in_ch_ff == CH_DOT || in_ch_ff == CH_DASH) begin
         verdict = ERR_LAST;
      end else begin
         verdict = ERR_OK;
      end
   end

   // run state update, cleared after each verdict
   always_comb begin
      count_in = count_ff;
      prev_in  = prev_ff;
      pmode_in = pmode_ff;
      accum_in = accum_ff;
      ferr_in  = ferr_ff;
      if (step) begin
         if (in_last_ff) begin
            count_in = '0;
            prev_in  = '0;
            pmode_in = 1'b0;
            accum_in = '0;
            ferr_in  = ERR_OK;
         end else begin
            count_in = count_next;
            prev_in  = in_ch_ff;
            pmode_in = pmode_next;
            accum_in = accum_next;
            ferr_in  = err_c;
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_err_in   = out_err_ff;
      out_hasp_in  = out_hasp_ff;
      out_port_in  = out_port_ff;
      out_len_in   = out_len_ff;
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (step && in_last_ff) begin
         out_valid_in = 1'b1;
         out_ok_in    = (verdict == ERR_OK);
         out_err_in   = verdict;
         out_hasp_in  = pmode_next;
         out_port_in  = (pmode_next && verdict == ERR_OK) ? accum_next[PORT_W-1:0] : '0;
         out_len_in   = count_next;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.valid_res   = out_ok_ff;
   assign rsp_bus.error       = out_err_ff;
   assign rsp_bus.has_port    = out_hasp_ff;
   assign rsp_bus.port        = out_port_ff;
   assign rsp_bus.auth_length = out_len_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         count_ff      <= '0;
         prev_ff       <= '0;
         pmode_ff      <= 1'b0;
         accum_ff      <= '0;
         ferr_ff       <= ERR_OK;
         out_valid_ff  <= 1'b0;
      end else begin
         max_length_ff <= max_length_in;
         in_valid_ff   <= in_valid_in;
         count_ff      <= count_in;
         prev_ff       <= prev_in;
         pmode_ff      <= pmode_in;
         accum_ff      <= accum_in;
         ferr_ff       <= ferr_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ch_ff    <= in_ch_in;
      in_last_ff  <= in_last_in;
      out_ok_ff   <= out_ok_in;
      out_err_ff  <= out_err_in;
      out_hasp_ff <= out_hasp_in;
      out_port_ff <= out_port_in;
      out_len_ff  <= out_len_in;
   end

endmodule

// ----- hdl/ahpc_checker.sv -----
// ----------------------------------------------------------------------------
// ahpc_checker
// Port-level checks on the verdicts of authority_host_port_check.
// ----------------------------------------------------------------------------
module ahpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_valid_res,
   input logic [ahpc_pkg::ERR_W-1:0]     rsp_error,
   input logic                           rsp_has_port,
   input logic [ahpc_pkg::PORT_W-1:0]    rsp_port
);
   import ahpc_pkg::*;

   // pass flag agrees with the code
   a_pass_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_valid_res == (rsp_error == ERR_OK)))
      else $error("valid_res disagrees with error code");

   // a port value only shows on a clean verdict with a port
   a_port_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_has_port || rsp_error != ERR_OK)) |-> (rsp_port == '0))
      else $error("port value shown without a clean port");

   // a port range failure needs a port
   a_range_needs_port: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error == ERR_PORT) |-> rsp_has_port)
      else $error("port range error without a port");

   // no verdict right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("verdict valid right after reset");

endmodule

bind authority_host_port_check ahpc_checker u_ahpc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_valid_res (rsp_bus.valid_res),
   .rsp_error     (rsp_bus.error),
   .rsp_has_port  (rsp_bus.has_port),
   .rsp_port      (rsp_bus.port)
);
